@@ sv/npm_pkg.sv @@
// ----------------------------------------------------------------------------
// npm_pkg
// shared types and constants of the negacyclic polynomial multiplier
// ----------------------------------------------------------------------------
`default_nettype none

package npm_pkg;

  // fixed field widths of the request and result payloads and of the degree register
  localparam int COEF_W  = 31;
  localparam int INDEX_W = 6;
  localparam int DEG_W   = 7;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MODULUS = 1'b0;
  localparam cfg_idx_t CFG_DEGREE  = 1'b1;

  localparam logic [COEF_W-1:0] MODULUS_RESET = 31'd12289;
  localparam logic [DEG_W-1:0]  DEGREE_RESET  = 7'd64;

  typedef struct packed {
    logic [COEF_W-1:0] a_coef;
    logic [COEF_W-1:0] b_coef;
    logic              last_in;
  } in_req_t;

  typedef struct packed {
    logic [COEF_W-1:0]  product_coef;
    logic [INDEX_W-1:0] coef_index;
    logic               last_out;
  } out_res_t;

endpackage

`default_nettype wire

@@ sv/npm_ram.sv @@
// ----------------------------------------------------------------------------
// npm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module npm_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/npm_modmul.sv @@
// ----------------------------------------------------------------------------
// npm_modmul
// bit-serial interleaved modular multiplier: result = x * y mod q, y < q
// ----------------------------------------------------------------------------
`default_nettype none

module npm_modmul #(
  parameter int W = 31
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] x,
  input  wire logic [W-1:0] y,
  input  wire logic [W-1:0] q,
  output logic              done,
  output logic      [W-1:0] result
);

  localparam int CNTW = $clog2(W + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]    x_r, x_nxt;
  logic [W-1:0]    y_r, y_nxt;
  logic [W-1:0]    q_r, q_nxt;
  logic [W-1:0]    acc_r, acc_nxt;

  // one step: acc = 2*acc + bit*y, then at most two subtractions of q
  logic [W+1:0] step_sum;
  logic [W+1:0] q1_ext;
  logic [W+1:0] q2_ext;

  always_comb begin
    q1_ext   = {2'b00, q_r};
    q2_ext   = {1'b0, q_r, 1'b0};
    step_sum = {1'b0, acc_r, 1'b0} + (x_r[W-1] ? {2'b00, y_r} : '0);

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    q_nxt    = q_r;
    acc_nxt  = acc_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(W);
      x_nxt    = x;
      y_nxt    = y;
      q_nxt    = q;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (step_sum >= q2_ext) begin
        acc_nxt = W'(step_sum - q2_ext);
      end else if (step_sum >= q1_ext) begin
        acc_nxt = W'(step_sum - q1_ext);
      end else begin
        acc_nxt = W'(step_sum);
      end
      x_nxt   = {x_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    q_r   <= q_nxt;
    acc_r <= acc_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

`default_nettype wire

@@ sv/negacyclic_poly_multiply_mod_q.sv @@
// ----------------------------------------------------------------------------
// negacyclic_poly_multiply_mod_q
// schoolbook product of two polynomials modulo x^n + 1 and modulo q
// ----------------------------------------------------------------------------
// Each request loads coefficient pair k of both operands; a request with
// last_in set starts the product c = a * b mod (x^n + 1, q), where positions
// not loaded count as zero. Results leave in index order, one strobe on
// out_valid per coefficient, and the receiver cannot stall them: they must be
// taken in the cycle they appear. A loading request keeps busy high while
// both operands are reduced mod q in parallel by two bit-serial units, one
// bit a cycle, and written to the operand rams; a request that arrives with
// the store already full loads nothing and only starts the product if
// last_in is set. The product is built one coefficient at a time: for each k
// every i below the used count is visited (a present paired term is read
// from the operand rams and formed by the bit-serial modular multiplier, an
// absent one is skipped), then the sweep closes and c[k] is emitted. A stored
// second operand that is not below q, which only happens after a modulus
// write between loads, is reduced again before its term is formed. The user
// must write configuration only while busy is low and no results are
// pending; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module negacyclic_poly_multiply_mod_q #(
  parameter int MAX_DEGREE = 64,
  parameter int COEF_BITS  = 31
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // request channel
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire npm_pkg::in_req_t                      in_data,
  // result channel
  output logic                                       out_valid,
  output npm_pkg::out_res_t                          out_data,
  // configuration write port
  input  wire logic                                  cfg_we,
  input  wire logic [npm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [npm_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  import npm_pkg::*;

  localparam int AW = $clog2(MAX_DEGREE);
  localparam int NW = $clog2(MAX_DEGREE + 1);
  localparam int W  = COEF_BITS;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_PSTART = 3'd2;
  localparam logic [2:0] ST_TERM   = 3'd3;
  localparam logic [2:0] ST_RD     = 3'd4;
  localparam logic [2:0] ST_MUL    = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;
  localparam logic [2:0] ST_RED    = 3'd7;

  // configuration registers
  logic [COEF_W-1:0] modulus_r;
  logic [DEG_W-1:0]  degree_r;

  // sequencer registers
  logic [2:0]    state_r, state_nxt;
  logic [NW-1:0] loaded_r, loaded_nxt;
  logic          last_r, last_nxt;
  logic [NW-1:0] used_r, used_nxt;
  logic [NW-1:0] k_r, k_nxt;
  logic [NW-1:0] i_r, i_nxt;
  logic          neg_r, neg_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_res_t      out_data_r, out_data_nxt;

  // effective modulus and degree
  logic [W-1:0]  q_cfg;
  logic [W-1:0]  q_eff;
  logic [31:0]   deg_ext;
  logic [NW-1:0] n_eff;

  // operand rams
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] a_raddr;
  logic [AW-1:0] b_raddr;
  logic [W-1:0]  a_rdata;
  logic [W-1:0]  b_rdata;

  // modular multipliers: unit 0 reduces a and forms the terms, unit 1 reduces b
  logic          mul0_start, mul1_start;
  logic [W-1:0]  mul0_x, mul0_y;
  logic [W-1:0]  mul1_x;
  logic          mul0_done, mul1_done;
  logic [W-1:0]  mul0_res, mul1_res;

  logic          accept;
  logic          store_ok;
  logic [W-1:0]  a_in, b_in;
  logic [NW:0]   j_full;
  logic          term_ok;
  logic          b_lt_q;
  logic [W:0]    add_sum;
  logic [W:0]    sub_res;

  always_comb begin
    q_cfg   = modulus_r[W-1:0];
    q_eff   = (q_cfg < W'(2)) ? W'(1) : q_cfg;
    deg_ext = 32'(degree_r);
    if (degree_r == '0) begin
      n_eff = NW'(1);
    end else if (deg_ext > 32'(MAX_DEGREE)) begin
      n_eff = NW'(MAX_DEGREE);
    end else begin
      n_eff = NW'(deg_ext);
    end
  end

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign store_ok = (loaded_r < n_eff);
  assign a_in     = in_data.a_coef[W-1:0];
  assign b_in     = in_data.b_coef[W-1:0];

  // partner index of term (i, k); wrapped terms come back negated
  always_comb begin
    if (i_r <= k_r) begin
      j_full = {1'b0, k_r} - {1'b0, i_r};
    end else begin
      j_full = {1'b0, k_r} + {1'b0, n_eff} - {1'b0, i_r};
    end
    term_ok = (j_full < {1'b0, used_r});
  end

  assign a_raddr   = i_r[AW-1:0];
  assign b_raddr   = AW'(j_full);
  assign ram_we    = (state_r == ST_LOAD) && mul0_done;
  assign ram_waddr = loaded_r[AW-1:0];

  // the multiplier needs its second operand below q; a stored value loaded
  // under an older modulus takes a detour through unit 1 first
  assign b_lt_q = (b_rdata < q_eff);

  assign mul0_start = (accept && store_ok) || ((state_r == ST_RD) && b_lt_q) ||
                      ((state_r == ST_RED) && mul1_done);
  assign mul1_start = (accept && store_ok) || ((state_r == ST_RD) && !b_lt_q);
  assign mul0_x     = ((state_r == ST_RD) || (state_r == ST_RED)) ? a_rdata : a_in;
  assign mul0_y     = (state_r == ST_RD)  ? b_rdata :
                      (state_r == ST_RED) ? mul1_res : W'(1);
  assign mul1_x     = (state_r == ST_RD) ? b_rdata : b_in;

  // modular add and subtract of a finished term into the running sum
  always_comb begin
    add_sum = {1'b0, acc_r} + {1'b0, mul0_res};
    if (add_sum >= {1'b0, q_eff}) begin
      add_sum = add_sum - {1'b0, q_eff};
    end
    if (acc_r >= mul0_res) begin
      sub_res = {1'b0, acc_r} - {1'b0, mul0_res};
    end else begin
      sub_res = {1'b0, acc_r} + {1'b0, q_eff} - {1'b0, mul0_res};
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    last_nxt      = last_r;
    used_nxt      = used_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          last_nxt = in_data.last_in;
          if (store_ok) begin
            state_nxt = ST_LOAD;
          end else if (in_data.last_in) begin
            // store already full: the request only starts the product
            state_nxt = ST_PSTART;
          end
        end
      end
      ST_LOAD: begin
        if (mul0_done) begin
          loaded_nxt = loaded_r + NW'(1);
          state_nxt  = last_r ? ST_PSTART : ST_IDLE;
        end
      end
      ST_PSTART: begin
        // degree may have shrunk since loading began
        used_nxt  = (loaded_r < n_eff) ? loaded_r : n_eff;
        k_nxt     = '0;
        i_nxt     = '0;
        acc_nxt   = '0;
        state_nxt = ST_TERM;
      end
      ST_TERM: begin
        if (i_r == used_r) begin
          state_nxt = ST_EMIT;
        end else if (term_ok) begin
          // ram addresses are presented this cycle
          neg_nxt   = (i_r > k_r);
          state_nxt = ST_RD;
        end else begin
          i_nxt = i_r + NW'(1);
        end
      end
      ST_RD: begin
        state_nxt = b_lt_q ? ST_MUL : ST_RED;
      end
      ST_RED: begin
        // read data stays put: addresses hold and the rams are not written
        if (mul1_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul0_done) begin
          acc_nxt   = neg_r ? W'(sub_res) : W'(add_sum);
          i_nxt     = i_r + NW'(1);
          state_nxt = ST_TERM;
        end
      end
      ST_EMIT: begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.product_coef = COEF_W'(acc_r);
        out_data_nxt.coef_index   = INDEX_W'(k_r);
        out_data_nxt.last_out     = (k_r == n_eff - NW'(1));
        if (k_r == n_eff - NW'(1)) begin
          loaded_nxt = '0;
          state_nxt  = ST_IDLE;
        end else begin
          k_nxt     = k_r + NW'(1);
          i_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = ST_TERM;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loaded_r    <= '0;
      out_valid_r <= 1'b0;
      modulus_r   <= MODULUS_RESET;
      degree_r    <= DEGREE_RESET;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_MODULUS) begin
          modulus_r <= cfg_wdata[COEF_W-1:0];
        end else if (cfg_index == CFG_DEGREE) begin
          degree_r <= cfg_wdata[DEG_W-1:0];
        end
      end
    end
    last_r     <= last_nxt;
    used_r     <= used_nxt;
    k_r        <= k_nxt;
    i_r        <= i_nxt;
    neg_r      <= neg_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // first operand store
  npm_ram #(
    .WIDTH (W),
    .DEPTH (MAX_DEGREE)
  ) u_a_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (mul0_res),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  // second operand store
  npm_ram #(
    .WIDTH (W),
    .DEPTH (MAX_DEGREE)
  ) u_b_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (mul1_res),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // load-time reduction of a, and the term products
  npm_modmul #(
    .W (W)
  ) u_mul0 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul0_start),
    .x      (mul0_x),
    .y      (mul0_y),
    .q      (q_eff),
    .done   (mul0_done),
    .result (mul0_res)
  );

  // load-time reduction of b, and re-reduction of a stale stored b
  npm_modmul #(
    .W (W)
  ) u_mul1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul1_start),
    .x      (mul1_x),
    .y      (W'(1)),
    .q      (q_eff),
    .done   (mul1_done),
    .result (mul1_res)
  );

endmodule

`default_nettype wire
